### rtl/tpy_pkg.sv
// Shared types, constants and palette function for the thermal palette converter.
`timescale 1ns / 1ps
package tpy_pkg;

  localparam int PALETTE_SIZE = 80;
  localparam int PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int RGB_W        = 24;
  localparam int ACC_W        = 26;   // signed Q8.16 accumulator with headroom

  // BT.601 coefficients, Q0.16
  localparam logic [15:0] C_Y_R  = 16'd16843;
  localparam logic [15:0] C_Y_G  = 16'd33030;
  localparam logic [15:0] C_Y_B  = 16'd6423;
  localparam logic [15:0] C_CR_R = 16'd28770;
  localparam logic [15:0] C_CR_G = 16'd24117;
  localparam logic [15:0] C_CR_B = 16'd4653;
  localparam logic [15:0] C_CB_R = 16'd9699;
  localparam logic [15:0] C_CB_G = 16'd19071;
  localparam logic [15:0] C_CB_B = 16'd28770;

  localparam logic [ACC_W-1:0] OFS_Y = ACC_W'(16 << 16);
  localparam logic [ACC_W-1:0] OFS_C = ACC_W'(128 << 16);

  // Per-beat sideband riding along with the palette read and the matrix stages
  typedef struct packed {
    logic valid;
    logic cvalid;
  } tpy_meta_t;

  // Palette RAM write port
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [RGB_W-1:0]  data;
  } tpy_wr_t;

  // Palette color for one index, packed {R, G, B}
  function automatic logic [RGB_W-1:0] palette_color(input logic [PAL_AW-1:0] idx);
    logic [7:0] k;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    if (idx < PAL_AW'(20)) begin
      k = 8'(idx);
      r = 8'd0;
      g = 8'(k * 8'd10);
      b = 8'd255;
    end else if (idx < PAL_AW'(40)) begin
      k = 8'(idx) - 8'd20;
      r = 8'(k * 8'd12);
      g = 8'd200 + 8'(k * 8'd2);
      b = 8'd255 - 8'(k * 8'd8);
    end else if (idx < PAL_AW'(60)) begin
      k = 8'(idx) - 8'd40;
      r = 8'd255;
      g = 8'd255 - 8'(k * 8'd3);
      b = 8'd95 - 8'(k * 8'd5);
    end else begin
      k = 8'(idx) - 8'd60;
      r = 8'd255;
      g = 8'd200 - 8'(k * 8'd10);
      b = 8'd0;
    end
    return {r, g, b};
  endfunction

  // Q8.16 to 8 bits: negative floors at 0, overflow saturates
  function automatic logic [7:0] finish_q16(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-17:0] whole;
    whole = acc[ACC_W-1:16];
    if (acc < 0) begin
      return 8'd0;
    end else if (whole > (ACC_W-16)'(255)) begin
      return 8'd255;
    end else begin
      return whole[7:0];
    end
  endfunction

endpackage

### rtl/thermal_palette_to_yuv420.sv
// Top level: thermal index stream to palette RGB plus BT.601 YCbCr 4:2:0 samples.
`timescale 1ns / 1ps
// Takes one 7-bit temperature index per beat in raster order and returns, per beat,
// the palette RGB color, BT.601 luma, and Cr/Cb on pixels of even rows and even
// columns (out_tuser high; chroma bytes read zero elsewhere). Indices above 79 use
// the last palette entry. in_tuser marks the first pixel of a frame and restarts
// the row/column tracking; line_width (cfg port, saturated to 2..MAX_LINE_WIDTH)
// sets where rows wrap. Throughput is one pixel per clock once the palette is loaded
// and while out_tready is high; each beat passes the palette RAM read, the multiply
// stage and the sum/round stage into the output register. The palette lives in an
// 80x24 RAM that is loaded by a sweep after reset; in_tready stays low until the
// sweep is done. Config writes are accepted at any time but should only be
// issued while the pipeline is empty. The pipeline stalls as a whole while a
// result waits on out_tready, so in_tready follows out_tready combinationally.
module thermal_palette_to_yuv420 #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] pixel_index, [7] zero pad
  input  logic        in_tuser,   // [0] start_of_frame
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                  // [31:24] luma, [39:32] chroma_red_diff,
                                  // [47:40] chroma_blue_diff
  output logic        out_tuser,  // [0] chroma_valid
  // line_width register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  import tpy_pkg::*;

  localparam int COL_W  = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int LW_MIN = $clog2(MAX_LINE_WIDTH + 1);
  localparam int LW_W   = (LW_MIN > 11) ? LW_MIN : 11;

  // ---------------------------------------------------------------- control
  logic adv;          // whole pipeline moves this cycle
  logic accept;
  logic fill_done;
  tpy_wr_t pal_wr;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = fill_done && adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- line_width
  logic [LW_W-1:0] line_width_r;
  logic [LW_W-1:0] line_width_nxt;

  always_comb begin
    line_width_nxt = line_width_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_data < 11'd2) begin
        line_width_nxt = LW_W'(2);
      end else if (32'(cfg_data) > 32'(MAX_LINE_WIDTH)) begin
        line_width_nxt = LW_W'(MAX_LINE_WIDTH);
      end else begin
        line_width_nxt = LW_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_W'(640);
    end else begin
      line_width_r <= line_width_nxt;
    end
  end

  // ---------------------------------------------------------------- raster position
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic             row_odd_r;
  logic             row_odd_nxt;
  logic [COL_W-1:0] col_cur;
  logic             row_cur;
  logic [COL_W:0]   col_inc;
  logic             cvalid_cur;

  always_comb begin
    // start of frame puts this pixel at column 0 of an even row
    col_cur     = in_tuser ? '0 : col_r;
    row_cur     = in_tuser ? 1'b0 : row_odd_r;
    cvalid_cur  = !row_cur && !col_cur[0];
    col_inc     = (COL_W+1)'(col_cur) + (COL_W+1)'(1);
    col_nxt     = col_r;
    row_odd_nxt = row_odd_r;
    if (accept) begin
      // also covers a width lowered mid-row: the row ends after this pixel
      if (32'(col_inc) >= 32'(line_width_r)) begin
        col_nxt     = '0;
        row_odd_nxt = !row_cur;
      end else begin
        col_nxt     = col_inc[COL_W-1:0];
        row_odd_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_odd_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_odd_r <= row_odd_nxt;
    end
  end

  // ---------------------------------------------------------------- palette lookup
  logic [PAL_AW-1:0] pal_idx;
  logic [RGB_W-1:0]  pal_rgb;
  tpy_meta_t         rd_meta_r;

  assign pal_idx = (in_tdata[6:0] > 7'(PALETTE_SIZE - 1)) ? PAL_AW'(PALETTE_SIZE - 1)
                                                          : PAL_AW'(in_tdata[6:0]);

  tpy_fill u_fill (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (pal_wr),
    .done (fill_done)
  );

  // pixels are only accepted once the loader is done, so no valid read overlaps a write
  tpy_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PALETTE_SIZE)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_wr.en),
    .wr_addr(pal_wr.addr),
    .wr_data(pal_wr.data),
    .rd_en  (adv),
    .rd_addr(pal_idx),
    .rd_data(pal_rgb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_meta_r <= '0;
    end else if (adv) begin
      rd_meta_r.valid  <= accept;
      rd_meta_r.cvalid <= cvalid_cur;
    end
  end

  // ---------------------------------------------------------------- color matrix
  tpy_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .meta_in   (rd_meta_r),
    .rgb_in    (pal_rgb),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_cvalid(out_tuser)
  );

  // ---------------------------------------------------------------- assertions
  a_no_accept_during_fill : assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> !in_tready)
    else $error("pixel accepted while palette still loading");

  a_chroma_zero_off_grid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[47:32] == 16'd0))
    else $error("chroma nonzero on non-sampled pixel");

  a_luma_floor : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:24] >= 8'd16))
    else $error("luma below BT.601 black level");

  a_width_floor : assert property (@(posedge clk) disable iff (!rst_n)
    line_width_r >= LW_W'(2))
    else $error("line width below minimum");

  a_stall_holds_read : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(rd_meta_r))
    else $error("palette read stage moved during stall");

endmodule

### rtl/tpy_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module tpy_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/tpy_fill.sv
// Palette loader: sweeps the fixed color ramp into the palette RAM after reset.
`timescale 1ns / 1ps
module tpy_fill (
  input  logic            clk,
  input  logic            rst_n,
  output tpy_pkg::tpy_wr_t wr,
  output logic            done
);
  import tpy_pkg::*;

  logic [PAL_AW-1:0] cnt_r;
  logic [PAL_AW-1:0] cnt_nxt;
  logic              done_r;
  logic              done_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (!done_r) begin
      if (cnt_r == PAL_AW'(PALETTE_SIZE - 1)) begin
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + PAL_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign wr.en   = !done_r;
  assign wr.addr = cnt_r;
  assign wr.data = palette_color(cnt_r);
  assign done    = done_r;

endmodule

### rtl/tpy_color.sv
// BT.601 color matrix: product stage, then sum/round stage into the output register.
`timescale 1ns / 1ps
module tpy_color (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  tpy_pkg::tpy_meta_t        meta_in,
  input  logic [tpy_pkg::RGB_W-1:0] rgb_in,
  output logic                      out_valid,
  output logic [47:0]               out_data,
  output logic                      out_cvalid
);
  import tpy_pkg::*;

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;

  // product stage
  logic              p_valid_r;
  logic              p_cvalid_r;
  logic [23:0]       p_yr_r, p_yg_r, p_yb_r;
  logic [23:0]       p_crr_r, p_crg_r, p_crb_r;
  logic [23:0]       p_cbr_r, p_cbg_r, p_cbb_r;
  logic [RGB_W-1:0]  p_rgb_r;

  // output stage
  logic              o_valid_r;
  logic              o_cvalid_r;
  logic [47:0]       o_data_r;
  logic [47:0]       o_data_nxt;

  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_cr;
  logic signed [ACC_W-1:0] acc_cb;

  assign r = rgb_in[23:16];
  assign g = rgb_in[15:8];
  assign b = rgb_in[7:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_yr_r  <= 24'(r) * 24'(C_Y_R);
      p_yg_r  <= 24'(g) * 24'(C_Y_G);
      p_yb_r  <= 24'(b) * 24'(C_Y_B);
      p_crr_r <= 24'(r) * 24'(C_CR_R);
      p_crg_r <= 24'(g) * 24'(C_CR_G);
      p_crb_r <= 24'(b) * 24'(C_CR_B);
      p_cbr_r <= 24'(r) * 24'(C_CB_R);
      p_cbg_r <= 24'(g) * 24'(C_CB_G);
      p_cbb_r <= 24'(b) * 24'(C_CB_B);
      p_rgb_r <= rgb_in;
      p_cvalid_r <= meta_in.cvalid;
    end
  end

  always_comb begin
    acc_y  = $signed({2'b00, p_yr_r}) + $signed({2'b00, p_yg_r})
           + $signed({2'b00, p_yb_r}) + $signed(OFS_Y);
    acc_cr = $signed({2'b00, p_crr_r}) - $signed({2'b00, p_crg_r})
           - $signed({2'b00, p_crb_r}) + $signed(OFS_C);
    acc_cb = $signed({2'b00, p_cbb_r}) - $signed({2'b00, p_cbr_r})
           - $signed({2'b00, p_cbg_r}) + $signed(OFS_C);
    o_data_nxt[7:0]   = p_rgb_r[23:16];
    o_data_nxt[15:8]  = p_rgb_r[15:8];
    o_data_nxt[23:16] = p_rgb_r[7:0];
    o_data_nxt[31:24] = finish_q16(acc_y);
    // chroma forced to zero off the 4:2:0 sample grid
    o_data_nxt[39:32] = p_cvalid_r ? finish_q16(acc_cr) : 8'd0;
    o_data_nxt[47:40] = p_cvalid_r ? finish_q16(acc_cb) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data_r   <= o_data_nxt;
      o_cvalid_r <= p_cvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= meta_in.valid;
      o_valid_r <= p_valid_r;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_data   = o_data_r;
  assign out_cvalid = o_cvalid_r;

endmodule

### tb/sv/thermal_palette_to_yuv420_test.sv
// Testbench for the thermal palette to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps
// Drives palette indices on the input stream and checks every result beat against
// a local model of the block: the palette ramps, BT.601 Q0.16 arithmetic and the
// row/column parity tracking that gates chroma. Both stream sides idle at random.
// The line_width register is rewritten only when the pipeline is empty, between
// and within phases. Phases run in this order:
//   - palette band edges
//   - narrow and odd row widths
//   - a width cut in the middle of a row
//   - a long receiver hold-off that backs up the input
//   - random frames over many widths
//   - a long run at the saturated maximum width
module thermal_palette_to_yuv420_test;

  localparam int WIDTH_CAP    = 1024;     // MAX_LINE_WIDTH of the instance
  localparam int HOLD_CYCLES  = 48;       // long receiver hold-off
  localparam int CYCLE_LIMIT  = 600000;   // run aborts past this
  localparam int SETTLE       = 6;        // exceeds the pipeline latency
  localparam int RANDOM_ITEMS = 300;      // pixels in the random frame phase
  localparam int WIDEST_RUN   = 200;      // pixels at the saturated width

  // BT.601 coefficients, Q0.16
  localparam longint KY_R  = 16843;
  localparam longint KY_G  = 33030;
  localparam longint KY_B  = 6423;
  localparam longint KCR_R = 28770;
  localparam longint KCR_G = 24117;
  localparam longint KCR_B = 4653;
  localparam longint KCB_R = 9699;
  localparam longint KCB_G = 19071;
  localparam longint KCB_B = 28770;
  localparam longint OFS_LUMA   = longint'(16) << 16;
  localparam longint OFS_CHROMA = longint'(128) << 16;

  // Indices at the ends of each palette band, plus the clamped range
  localparam logic [6:0] BAND_EDGES [10] = '{7'd0, 7'd19, 7'd20, 7'd39, 7'd40,
                                             7'd59, 7'd60, 7'd79, 7'd80, 7'd127};

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] luma;
    logic [7:0] cr;
    logic [7:0] cb;
    logic       chroma_valid;
  } pix_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [6:0] pixel_index, [7] zero pad
  logic        in_tuser;    // [0] start_of_frame
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] luma,
                            // [39:32] chroma_red_diff, [47:40] chroma_blue_diff
  logic        out_tuser;   // [0] chroma_valid
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  // Model state: raster position and the current row width
  logic [9:0]  col_pos;
  logic        odd_row;
  logic [10:0] row_width;

  pix_result_t expected_pixels[$];
  int          fail_count;
  int          cycle_count;
  bit          no_idle;     // both sides run without gaps while set
  bit          hold_req;    // asks the sink for one long hold-off

  thermal_palette_to_yuv420 #(
    .MAX_LINE_WIDTH(WIDTH_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------- model

  // False-color ramp: four 20-entry bands
  function automatic void thermal_rgb(input int entry, output int r, output int g,
                                      output int b);
    int k;
    k = entry % 20;
    if (entry < 20) begin
      r = 0;       g = 10 * k;            b = 255;
    end else if (entry < 40) begin
      r = 12 * k;  g = 200 + 2 * k;       b = 255 - 8 * k;
    end else if (entry < 60) begin
      r = 255;     g = 255 - 3 * k;       b = 95 - 5 * k;
    end else begin
      r = 255;     g = 200 - 10 * k;      b = 0;
    end
  endfunction

  // Q8.16 sum to a byte: truncate, floor at 0, saturate at 255
  function automatic logic [7:0] q16_to_byte(input longint acc);
    longint whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> 16;
    return (whole > 255) ? 8'd255 : 8'(whole);
  endfunction

  // One pixel through the converter; advances the raster position
  function automatic pix_result_t convert_pixel(input logic [6:0] idx, input logic sof);
    pix_result_t res;
    int entry;
    int r;
    int g;
    int b;
    if (sof) begin
      col_pos = '0;
      odd_row = 1'b0;
    end
    entry = (idx >= tpy_pkg::PALETTE_SIZE) ? tpy_pkg::PALETTE_SIZE - 1 : int'(idx);
    thermal_rgb(entry, r, g, b);
    res.red   = 8'(r);
    res.green = 8'(g);
    res.blue  = 8'(b);
    res.luma  = q16_to_byte(KY_R * r + KY_G * g + KY_B * b + OFS_LUMA);
    res.chroma_valid = !odd_row && !col_pos[0];
    if (res.chroma_valid) begin
      res.cr = q16_to_byte(KCR_R * r - KCR_G * g - KCR_B * b + OFS_CHROMA);
      res.cb = q16_to_byte(-KCB_R * r - KCB_G * g + KCB_B * b + OFS_CHROMA);
    end else begin
      res.cr = 8'd0;
      res.cb = 8'd0;
    end
    // 10-bit column counter wraps on its own at 1024
    col_pos = col_pos + 10'd1;
    if (col_pos == 10'd0 || {1'b0, col_pos} >= row_width) begin
      col_pos = '0;
      odd_row = !odd_row;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- pacing

  // Mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [6:0] random_index();
    if ($urandom_range(0, 99) < 15) return BAND_EDGES[$urandom_range(0, 9)];
    return 7'($urandom_range(0, 127));
  endfunction

  // Sink side: random stalls, plus one long hold-off on request
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && out_tready) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    pix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("result beat with no pixel outstanding: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, out_tdata[7:0]);
        check_field("green", want.green, out_tdata[15:8]);
        check_field("blue", want.blue, out_tdata[23:16]);
        check_field("luma", want.luma, out_tdata[31:24]);
        check_field("chroma_red_diff", want.cr, out_tdata[39:32]);
        check_field("chroma_blue_diff", want.cb, out_tdata[47:40]);
        check_field("chroma_valid", {7'd0, want.chroma_valid}, {7'd0, out_tuser});
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- source side

  // One pixel beat; expectation recorded at the handshake
  task automatic send_pixel(input logic [6:0] idx, input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, idx};
    in_tuser  <= sof;
    do @(posedge clk); while (!in_tready);
    expected_pixels.push_back(convert_pixel(idx, sof));
  endtask

  // Source goes quiet until every result is back, then waits out the SETTLE margin
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_line_width(input logic [10:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // written value saturates into 2..WIDTH_CAP
    if (value < 11'd2) row_width = 11'd2;
    else if (value > 11'(WIDTH_CAP)) row_width = 11'(WIDTH_CAP);
    else row_width = value;
  endtask

  // Run of pixels starting a frame, with occasional stray frame starts
  task automatic send_frame(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(random_index(), (i == 0) || ($urandom_range(0, 49) == 0));
  endtask

  // ---------------------------------------------------------------- tests

  // Band edges and clamp at the reset width of 640
  task automatic test_palette_bands();
    send_pixel(7'd0, 1'b1);
    for (int i = 1; i < 10; i++) send_pixel(BAND_EDGES[i], 1'b0);
    send_pixel(7'd127, 1'b1);
    send_pixel(7'd85, 1'b0);
  endtask

  // Width writes below the minimum, then an odd width; a frame restart on an odd row
  task automatic test_narrow_rows();
    write_line_width(11'd0);
    for (int i = 0; i < 5; i++) send_pixel(7'(10 * i + 3), i == 0);
    write_line_width(11'd1);
    send_pixel(7'd45, 1'b1);
    send_pixel(7'd64, 1'b0);
    send_pixel(7'd31, 1'b1);   // frame start while on an odd row
    write_line_width(11'd3);
    for (int i = 0; i < 6; i++) send_pixel(7'(17 * i), i == 0);
  endtask

  // Shrink the row width after the column is already past it
  task automatic test_width_cut_mid_row();
    write_line_width(11'd40);
    send_frame(30);
    write_line_width(11'd8);
    for (int i = 0; i < 12; i++) send_pixel(random_index(), 1'b0);
  endtask

  // Receiver holds off long enough to stall the input side
  task automatic test_backpressure();
    write_line_width(11'd6);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    send_frame(40);
    no_idle  = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_frames();
    int sent;
    int count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) write_line_width(11'($urandom_range(0, 2047)));
      else write_line_width(11'($urandom_range(2, 24)));
      no_idle = ($urandom_range(0, 3) == 0);
      count = $urandom_range(20, 80);
      send_frame(count);
      sent += count;
    end
    no_idle = 1'b0;
  endtask

  // Over-range write saturates to the cap; a long run inside one row
  task automatic test_widest_row();
    write_line_width(11'd2047);
    send_pixel(random_index(), 1'b1);
    for (int i = 1; i < WIDEST_RUN; i++) begin
      no_idle = (i % 64) < 32;
      send_pixel(random_index(), 1'b0);
    end
    no_idle = 1'b0;
  endtask

  initial begin : run_tests
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    col_pos   = '0;
    odd_row   = 1'b0;
    row_width = 11'd640;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_palette_bands();
    test_narrow_rows();
    test_width_cut_mid_row();
    test_backpressure();
    test_random_frames();
    test_widest_row();

    wait_drained();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
